>>> sv/curve_sample_plot_mapper_assert.svh
// ----------------------------------------------------------------------------
// Curve sample plot mapper assertion macros
// Shared assertion forms for the mapper modules. Each module that asserts
// has i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CURVE_SAMPLE_PLOT_MAPPER_ASSERT_SVH
`define CURVE_SAMPLE_PLOT_MAPPER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Condition that must never hold out of reset.
`define CSPM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(cond)) else $error(msg);

`endif

>>> sv/cspm_pkg.sv
// ----------------------------------------------------------------------------
// Curve sample plot mapper package
// Widths, register indexes, result kinds and the control/status words
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cspm_pkg;

    // Default counter widths
    localparam int SAMPLE_INDEX_BITS_DEF = 20;
    localparam int POINT_INDEX_BITS_DEF  = 24;

    // Result field widths
    localparam int SAMPLE_NUM_W = 20;
    localparam int SEG_FIRST_W  = 24;
    localparam int SEG_COUNT_W  = 21;
    localparam int Q_W          = 32;
    localparam int UQ_W         = 31;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 200;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BOTTOM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_LEFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT  = 3'd7;

    // Register reset values
    localparam logic [Q_W-1:0]  ONE_Q16    = 32'h0001_0000;
    localparam logic [UQ_W-1:0] ONE_Q16_U  = 31'h0001_0000;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic                    capture;
        logic                    start;
        logic                    sel_depth;
        logic                    emit;
        t_kind                   kind;
        logic                    last;
        logic [SAMPLE_NUM_W-1:0] sample_number;
        logic [SEG_FIRST_W-1:0]  seg_first;
        logic [SEG_COUNT_W-1:0]  seg_count;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic busy;
        logic done;
        logic err;
        logic missing;
        logic curve_end;
        logic out_free;
    } t_stat;

endpackage

>>> sv/curve_sample_plot_mapper.sv
// ----------------------------------------------------------------------------
// Curve sample plot mapper
// Maps well-log samples onto a plot track and reports points, closed
// segments and overflow errors.
//
//   Channel   Dir  tdata (low bit up)                          tuser / tlast
//   s_axis    in   sample_depth[31:0] sample_value[63:32]      missing / curve_end
//   m_axis    out  x_position, y_position, sample_number,      kind / last
//                  point_depth, point_value, segment_first_point,
//                  segment_point_count, zero pad to 200 bits
//   cfg       in   i_cfg_index selects the register, i_cfg_data holds it
//
// A good sample is captured and checked, then mapped in two passes of
// one multiply plus a radix-4 divider on the shared datapath, then its
// results are issued. Reset is synchronous and restores the register
// defaults and clears all counters. One sample is in work at a time; a
// stalled result holds the controller before its next result.
// ----------------------------------------------------------------------------
module curve_sample_plot_mapper #(
    parameter int SAMPLE_INDEX_BITS = cspm_pkg::SAMPLE_INDEX_BITS_DEF,
    parameter int POINT_INDEX_BITS  = cspm_pkg::POINT_INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cspm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cspm_pkg::Q_W-1:0]        i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_depth[31:0], sample_value[63:32]
    input  logic [cspm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // missing[0]
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // x_position[31:0], y_position[63:32], sample_number[83:64],
    // point_depth[115:84], point_value[147:116], segment_first_point[171:148],
    // segment_point_count[192:172], zero[199:193]
    output logic [cspm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    cspm_pkg::t_cmd  w_cmd;
    cspm_pkg::t_stat w_stat;

    cspm_ctrl #(
        .SAMPLE_INDEX_BITS (SAMPLE_INDEX_BITS),
        .POINT_INDEX_BITS  (POINT_INDEX_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cspm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tdata     (s_axis_tdata),
        .i_s_missing   (s_axis_tuser[0]),
        .i_s_curve_end (s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser),
        .o_m_tlast     (m_axis_tlast)
    );

endmodule

>>> sv/cspm_dpath.sv
// ----------------------------------------------------------------------------
// Curve sample plot mapper datapath
// Holds the configuration, the captured sample and the result word. One
// shared multiply and radix-4 restoring divider maps either the value or
// the depth per start command, with Q16.16 range checks.
// ----------------------------------------------------------------------------
module cspm_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cspm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cspm_pkg::Q_W-1:0]        i_cfg_data,
    input  logic [cspm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_missing,
    input  logic                            i_s_curve_end,
    input  cspm_pkg::t_cmd                  i_cmd,
    output cspm_pkg::t_stat                 o_stat,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cspm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [1:0]                      o_m_tuser,
    output logic                            o_m_tlast
);

    localparam int PROD_W    = 63;
    localparam int QUO_W     = 34;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] STEP_MUL   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_INIT  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_POST1 = STEP_W'(2 + DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_POST2 = STEP_W'(3 + DIV_STEPS);

    // Configuration registers
    logic [31:0] r_vmin, r_vmax, r_dtop, r_dbot;
    logic        r_rev;
    logic [30:0] r_tl, r_tw, r_ph;

    // Captured sample
    logic [31:0] r_in_depth, r_in_value;
    logic        r_in_missing, r_in_end;

    // Arithmetic state
    logic              r_busy, r_done, r_sel;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg, r_cfg_bad, r_ovf;
    logic [31:0]       r_div, r_rem, r_off;
    logic [QUO_W-1:0]  r_low, r_quo;
    logic [31:0]       r_left, r_top;
    logic              r_err_v, r_err_d;

    // Output word
    logic        r_valid, r_last;
    logic [1:0]  r_kind;
    logic [31:0] r_o_left, r_o_top, r_o_depth, r_o_value;
    logic [19:0] r_o_sample;
    logic [23:0] r_o_first;
    logic [20:0] r_o_count;

    logic [32:0] w_num, w_diff, w_mag;
    logic [30:0] w_factor;
    logic [63:0] w_prod;
    logic [32:0] w_s1, w_s2;
    logic [34:0] w_m;
    logic        w_ovf_q;
    logic [31:0] w_off;
    logic [32:0] w_sum;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [32:0] div_bit(input logic [31:0] rem, input logic bin,
                                            input logic [31:0] d);
        logic [32:0] t;
        t = {rem, bin};
        if (t >= {1'b0, d}) begin
            div_bit = {1'b1, 32'(t - {1'b0, d})};
        end else begin
            div_bit = {1'b0, t[31:0]};
        end
    endfunction

    // Select numerator, range and scale factor
    always_comb begin
        if (i_cmd.sel_depth) begin
            w_num    = {r_in_depth[31], r_in_depth} - {r_dtop[31], r_dtop};
            w_diff   = {r_dbot[31], r_dbot} - {r_dtop[31], r_dtop};
            w_factor = r_ph;
        end else begin
            w_num    = r_rev ? ({r_vmax[31], r_vmax} - {r_in_value[31], r_in_value})
                             : ({r_in_value[31], r_in_value} - {r_vmin[31], r_vmin});
            w_diff   = {r_vmax[31], r_vmax} - {r_vmin[31], r_vmin};
            w_factor = r_tw;
        end
        w_mag  = w_num[32] ? (~w_num + 33'd1) : w_num;
        w_prod = 64'(w_mag) * 64'(w_factor);
    end

    // Two division steps per cycle
    always_comb begin
        w_s1 = div_bit(r_rem, r_low[QUO_W-1], r_div);
        w_s2 = div_bit(w_s1[31:0], r_low[QUO_W-2], r_div);
    end

    // Floor correction and 32-bit range check
    always_comb begin
        w_m = 35'(r_quo) + 35'(r_rem != 32'd0);
        if (r_neg) begin
            w_ovf_q = (w_m > 35'h0_8000_0000);
            w_off   = 32'd0 - w_m[31:0];
        end else begin
            w_ovf_q = (r_quo[QUO_W-1:31] != '0);
            w_off   = r_quo[31:0];
        end
        w_sum = {2'b00, r_tl} + {r_off[31], r_off};
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= '0;
            r_vmax <= cspm_pkg::ONE_Q16;
            r_rev  <= 1'b0;
            r_dtop <= '0;
            r_dbot <= cspm_pkg::ONE_Q16;
            r_tl   <= '0;
            r_tw   <= cspm_pkg::ONE_Q16_U;
            r_ph   <= cspm_pkg::ONE_Q16_U;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cspm_pkg::REG_VALUE_MIN:    r_vmin <= i_cfg_data;
                cspm_pkg::REG_VALUE_MAX:    r_vmax <= i_cfg_data;
                cspm_pkg::REG_REVERSED:     r_rev  <= i_cfg_data[0];
                cspm_pkg::REG_DEPTH_TOP:    r_dtop <= i_cfg_data;
                cspm_pkg::REG_DEPTH_BOTTOM: r_dbot <= i_cfg_data;
                cspm_pkg::REG_TRACK_LEFT:   r_tl   <= i_cfg_data[30:0];
                cspm_pkg::REG_TRACK_WIDTH:  r_tw   <= i_cfg_data[30:0];
                cspm_pkg::REG_PLOT_HEIGHT:  r_ph   <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_depth   <= i_s_tdata[31:0];
            r_in_value   <= i_s_tdata[63:32];
            r_in_missing <= i_s_missing;
            r_in_end     <= i_s_curve_end;
        end
    end

    // Step sequencer of the shared unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_MUL;
            end else if (r_busy) begin
                if (r_step == STEP_POST2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Multiply, divide and post-process
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_err_v <= 1'b0;
            r_err_d <= 1'b0;
        end
        if (i_cmd.start) begin
            r_sel     <= i_cmd.sel_depth;
            r_prod    <= w_prod[PROD_W-1:0];
            r_neg     <= w_num[32];
            r_div     <= w_diff[31:0];
            r_cfg_bad <= w_diff[32] | (w_diff == 33'd0);
        end else if (r_busy) begin
            if (r_step == STEP_INIT) begin
                r_rem <= {3'b000, r_prod[PROD_W-1:QUO_W]};
                r_low <= r_prod[QUO_W-1:0];
                r_quo <= '0;
                r_ovf <= ({3'b000, r_prod[PROD_W-1:QUO_W]} >= r_div);
            end else if (r_step == STEP_POST1) begin
                r_off <= w_off;
                r_ovf <= r_ovf | w_ovf_q | r_cfg_bad;
            end else if (r_step == STEP_POST2) begin
                if (r_sel) begin
                    r_top   <= r_off;
                    r_err_d <= r_ovf;
                end else begin
                    r_left  <= w_sum[31:0];
                    r_err_v <= r_ovf | (w_sum[32] != w_sum[31]);
                end
            end else if (r_step != STEP_MUL) begin
                r_rem <= w_s2[31:0];
                r_quo <= {r_quo[QUO_W-3:0], w_s1[32], w_s2[32]};
                r_low <= {r_low[QUO_W-3:0], 2'b00};
            end
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind     <= i_cmd.kind;
            r_last     <= i_cmd.last;
            r_o_sample <= i_cmd.sample_number;
            r_o_first  <= i_cmd.seg_first;
            r_o_count  <= i_cmd.seg_count;
            if (i_cmd.kind == cspm_pkg::KIND_POINT) begin
                r_o_left  <= r_left;
                r_o_top   <= r_top;
                r_o_depth <= r_in_depth;
                r_o_value <= r_in_value;
            end else begin
                r_o_left  <= '0;
                r_o_top   <= '0;
                r_o_depth <= '0;
                r_o_value <= '0;
            end
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.done      = r_done;
    assign o_stat.err       = r_err_v | r_err_d;
    assign o_stat.missing   = r_in_missing;
    assign o_stat.curve_end = r_in_end;
    assign o_stat.out_free  = !r_valid || i_m_tready;

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {7'b0, r_o_count, r_o_first, r_o_value, r_o_depth,
                         r_o_sample, r_o_top, r_o_left};

endmodule

>>> sv/cspm_ctrl.sv
// ----------------------------------------------------------------------------
// Curve sample plot mapper controller
// Sequences one sample at a time: skip handling, value and depth mapping
// on the datapath, and the point, segment and error results. Owns the
// sample and point counters and the segment state.
// ----------------------------------------------------------------------------
`include "curve_sample_plot_mapper_assert.svh"

module cspm_ctrl #(
    parameter int SAMPLE_INDEX_BITS = cspm_pkg::SAMPLE_INDEX_BITS_DEF,
    parameter int POINT_INDEX_BITS  = cspm_pkg::POINT_INDEX_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  cspm_pkg::t_stat i_stat,
    output cspm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WVAL,
        S_WDEP,
        S_POINT,
        S_CLOSE,
        S_ERROR
    } t_state;

    t_state                        r_state;
    logic [SAMPLE_INDEX_BITS-1:0]  r_sc, r_this;
    logic [POINT_INDEX_BITS-1:0]   r_pc, r_seg_start;
    logic                          r_seg_open, r_skip;
    logic                          w_accept;
    logic                          w_end_emit;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_end_emit = (r_state == S_POINT) && o_cmd.emit && i_stat.curve_end;

    // Commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = w_accept;
        o_cmd.start     = ((r_state == S_CHECK) && !r_skip && !i_stat.missing)
                       || ((r_state == S_WVAL) && i_stat.done);
        o_cmd.sel_depth = (r_state == S_WVAL);
        o_cmd.kind      = cspm_pkg::KIND_POINT;
        o_cmd.last      = 1'b1;
        case (r_state)
            S_POINT: begin
                o_cmd.emit          = i_stat.out_free;
                o_cmd.last          = !i_stat.curve_end;
                o_cmd.sample_number = cspm_pkg::SAMPLE_NUM_W'(r_this);
            end
            S_CLOSE: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.kind      = cspm_pkg::KIND_SEGMENT;
                o_cmd.seg_first = cspm_pkg::SEG_FIRST_W'(r_seg_start);
                o_cmd.seg_count = cspm_pkg::SEG_COUNT_W'(
                                      POINT_INDEX_BITS'(r_pc - r_seg_start));
            end
            S_ERROR: begin
                o_cmd.emit          = i_stat.out_free;
                o_cmd.kind          = cspm_pkg::KIND_ERROR;
                o_cmd.sample_number = cspm_pkg::SAMPLE_NUM_W'(r_this);
            end
            default: begin
            end
        endcase
    end

    // State, counters and segment bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sc        <= '0;
            r_this      <= '0;
            r_pc        <= '0;
            r_seg_start <= '0;
            r_seg_open  <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_this  <= r_sc;
                        r_sc    <= r_sc + SAMPLE_INDEX_BITS'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_skip) begin
                        if (i_stat.curve_end) begin
                            r_skip <= 1'b0;
                            r_sc   <= '0;
                        end
                        r_state <= S_IDLE;
                    end else if (i_stat.missing) begin
                        if (r_seg_open) begin
                            r_state <= S_CLOSE;
                        end else begin
                            if (i_stat.curve_end) begin
                                r_sc <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_WVAL;
                    end
                end
                S_WVAL: begin
                    if (i_stat.done) begin
                        r_state <= S_WDEP;
                    end
                end
                S_WDEP: begin
                    if (i_stat.done) begin
                        r_state <= i_stat.err ? S_ERROR : S_POINT;
                    end
                end
                S_POINT: begin
                    if (i_stat.out_free) begin
                        if (!r_seg_open) begin
                            r_seg_open  <= 1'b1;
                            r_seg_start <= r_pc;
                        end
                        r_pc    <= r_pc + POINT_INDEX_BITS'(1);
                        r_state <= i_stat.curve_end ? S_CLOSE : S_IDLE;
                    end
                end
                S_CLOSE: begin
                    if (i_stat.out_free) begin
                        r_seg_open <= 1'b0;
                        if (i_stat.curve_end) begin
                            r_sc <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_ERROR: begin
                    if (i_stat.out_free) begin
                        r_seg_open <= 1'b0;
                        if (i_stat.curve_end) begin
                            r_sc <= '0;
                        end else begin
                            r_skip <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `CSPM_ASSERT_SAME(a_emit_free, o_cmd.emit, i_stat.out_free, "result word overwritten")
    `CSPM_ASSERT_SAME(a_start_idle, o_cmd.start, !i_stat.busy, "divider restarted while busy")
    `CSPM_ASSERT_NEVER(a_skip_no_seg, r_skip && r_seg_open, "segment open while skipping")
    `CSPM_ASSERT_NEXT(a_end_closes, w_end_emit, r_state == S_CLOSE, "curve end point not closed")

endmodule
